### src/assert_macros.svh
// assertion macros shared by the hash table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/htls_pkg.sv
// shared constants and codes for the hash table lookup and store block
package htls_pkg;

    // fixed field widths
    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int MOVE_W  = 16;
    localparam int KIND_W  = 8;
    localparam int CFG_W   = 13;

    // beat widths
    localparam int IN_DATA_W  = KEY_W + DEPTH_W + SCORE_W + MOVE_W + KIND_W;
    localparam int OUT_DATA_W = DEPTH_W + SCORE_W + MOVE_W + KIND_W;

    // parameter defaults
    localparam int SLOTS_DEF     = 4096;
    localparam int MOVE_BITS_DEF = 16;

    // table size after reset
    localparam logic [CFG_W-1:0] SIZE_RST = 13'd4093;

    // register indexes
    localparam logic CFG_MAIN  = 1'b0;
    localparam logic CFG_QUIES = 1'b1;

    // commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    // table selects
    localparam logic TBL_MAIN  = 1'b0;
    localparam logic TBL_QUIES = 1'b1;

endpackage

### src/htls_mod_unit.sv
// iterative remainder unit: key modulo table size, one quotient bit per cycle
`include "assert_macros.svh"

module htls_mod_unit #(
    parameter int KEY_W = htls_pkg::KEY_W,
    parameter int SZ_W  = htls_pkg::CFG_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic [SZ_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [SZ_W-1:0]  o_rem
);

    localparam int CNT_W = (KEY_W > 1) ? $clog2(KEY_W) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [KEY_W-1:0] r_key,  n_key;
    logic [SZ_W-1:0]  r_rem,  n_rem;
    logic [SZ_W-1:0]  r_div,  n_div;

    logic [SZ_W:0] w_part;
    logic [SZ_W:0] w_diff;
    logic          w_ge;

    // one restoring step: shift in the next key bit, subtract when it fits
    always_comb begin
        w_part = {r_rem, r_key[KEY_W-1]};
        w_diff = w_part - {1'b0, r_div};
        w_ge   = (w_part >= {1'b0, r_div});
    end

    // sequencing of the steps
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_key  = r_key;
        n_rem  = r_rem;
        n_div  = r_div;
        priority if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_key  = i_key;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_key = {r_key[KEY_W-2:0], 1'b0};
            n_rem = w_ge ? w_diff[SZ_W-1:0] : w_part[SZ_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(KEY_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    // checks
    `ASSERT_IMP(a_start_idle, i_start, !r_busy, "start while remainder unit busy")
    `ASSERT_NXT(a_done_pulse, r_done, !r_done, "done held longer than one cycle")
    `ASSERT_IMP(a_rem_below, r_busy || r_done, r_rem < r_div, "remainder not below divisor")

endmodule

### src/hash_table_lookup_store.sv
// top level: two direct-mapped hash tables with key lookup and always-replace store
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata key,depth,score,move,kind; tuser cmd,table
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata depth,score,move,kind; tuser hit
// cfg       in   i_cfg_wen (no wait)            i_cfg_index, i_cfg_wdata (table sizes)
//
// the key modulo the table size runs one quotient bit per cycle in the shared remainder
// unit, then the slot index is latched, one memory read follows and then a compare/write
// step; the block takes the next item only after the result of the last one is written.
// after reset a clearing pass zeroes both tables, with s_axis_tready low.
// a waiting result sits in the output register, so the next item is taken meanwhile;
// a result not yet taken holds the block at its compare step.
`include "assert_macros.svh"

module hash_table_lookup_store #(
    parameter int SLOTS     = htls_pkg::SLOTS_DEF,
    parameter int MOVE_BITS = htls_pkg::MOVE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // hash_key[63:0], search_depth[71:64], score_value[87:72], move_code[103:88],
    // node_kind[111:104]
    input  logic [htls_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd[0], table_select[1]
    input  logic [1:0]                        s_axis_tuser,
    // result beats
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_depth[7:0], out_score[23:8], out_move[39:24], out_node_kind[47:40]
    output logic [htls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // hit[0]
    output logic                              m_axis_tuser,
    // configuration writes
    input  logic                              i_cfg_wen,
    input  logic                              i_cfg_index,
    input  logic [htls_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int KEY_W   = htls_pkg::KEY_W;
    localparam int DEPTH_W = htls_pkg::DEPTH_W;
    localparam int SCORE_W = htls_pkg::SCORE_W;
    localparam int MOVE_W  = htls_pkg::MOVE_W;
    localparam int KIND_W  = htls_pkg::KIND_W;
    localparam int CFG_W   = htls_pkg::CFG_W;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLT_W   = $clog2(SLOTS + 1);
    localparam int SZ_W    = (CFG_W > SLT_W) ? CFG_W : SLT_W;

    // entry layout, key in the low bits
    localparam int MV_LO  = KEY_W;
    localparam int SC_LO  = MV_LO + MOVE_BITS;
    localparam int DP_LO  = SC_LO + SCORE_W;
    localparam int KD_LO  = DP_LO + DEPTH_W;
    localparam int ENT_W  = KD_LO + KIND_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // clearing pass
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;

    // table sizes
    logic [CFG_W-1:0] r_main_size;
    logic [CFG_W-1:0] r_quies_size;

    // captured item
    logic               r_cmd;
    logic               r_sel;
    logic [KEY_W-1:0]   r_key;
    logic [DEPTH_W-1:0] r_depth;
    logic [SCORE_W-1:0] r_score;
    logic [MOVE_W-1:0]  r_move;
    logic [KIND_W-1:0]  r_kind;
    logic [IDX_W-1:0]   r_idx;

    // result register
    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [htls_pkg::OUT_DATA_W-1:0] r_out_data;

    // memories and their read registers
    logic [ENT_W-1:0] mem_main  [SLOTS];
    logic [ENT_W-1:0] mem_quies [SLOTS];
    logic [ENT_W-1:0] r_rd_main;
    logic [ENT_W-1:0] r_rd_quies;

    logic             w_in_acc;
    logic             w_out_free;
    logic [CFG_W-1:0] w_raw_size;
    logic [SZ_W-1:0]  w_ext_size;
    logic [SZ_W-1:0]  w_eff_size;
    logic             w_div_done;
    logic [SZ_W-1:0]  w_rem;
    logic [ENT_W-1:0] w_new_ent;
    logic [ENT_W-1:0] w_rd_ent;
    logic [ENT_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_waddr;
    logic             w_we_main;
    logic             w_we_quies;
    logic             w_hit;

    // handshakes
    assign s_axis_tready = (r_state == ST_IDLE) && !r_clr_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // effective size of the selected table: zero acts as one, clamp to slots
    always_comb begin
        w_raw_size = (s_axis_tuser[1] == htls_pkg::TBL_QUIES) ? r_quies_size : r_main_size;
        w_ext_size = SZ_W'(w_raw_size);
        priority if (w_ext_size == '0) begin
            w_eff_size = SZ_W'(1);
        end else if (w_ext_size > SZ_W'(SLOTS)) begin
            w_eff_size = SZ_W'(SLOTS);
        end else begin
            w_eff_size = w_ext_size;
        end
    end

    // shared remainder unit
    htls_mod_unit #(
        .KEY_W (KEY_W),
        .SZ_W  (SZ_W)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_in_acc),
        .i_key     (s_axis_tdata[KEY_W-1:0]),
        .i_divisor (w_eff_size),
        .o_done    (w_div_done),
        .o_rem     (w_rem)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) n_state = ST_RD;
            end
            ST_RD: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(SLOTS - 1)) r_clr_busy <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_size  <= htls_pkg::SIZE_RST;
            r_quies_size <= htls_pkg::SIZE_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                htls_pkg::CFG_MAIN:  r_main_size  <= i_cfg_wdata;
                htls_pkg::CFG_QUIES: r_quies_size <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // capture the item and the slot index
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd   <= s_axis_tuser[0];
            r_sel   <= s_axis_tuser[1];
            r_key   <= s_axis_tdata[KEY_W-1:0];
            r_depth <= s_axis_tdata[KEY_W +: DEPTH_W];
            r_score <= s_axis_tdata[KEY_W+DEPTH_W +: SCORE_W];
            r_move  <= s_axis_tdata[KEY_W+DEPTH_W+SCORE_W +: MOVE_W];
            r_kind  <= s_axis_tdata[KEY_W+DEPTH_W+SCORE_W+MOVE_W +: KIND_W];
        end
        if (w_div_done) r_idx <= w_rem[IDX_W-1:0];
    end

    // write side: zeros during clearing, else the new entry on a store
    always_comb begin
        w_new_ent                       = '0;
        w_new_ent[KEY_W-1:0]            = r_key;
        w_new_ent[MV_LO +: MOVE_BITS]   = MOVE_BITS'(r_move);
        w_new_ent[SC_LO +: SCORE_W]     = r_score;
        w_new_ent[DP_LO +: DEPTH_W]     = r_depth;
        w_new_ent[KD_LO +: KIND_W]      = r_kind;
        w_wdata    = r_clr_busy ? '0 : w_new_ent;
        w_waddr    = r_clr_busy ? r_clr_addr : r_idx;
        w_we_main  = r_clr_busy || ((r_state == ST_FIN) && w_out_free
                     && (r_cmd == htls_pkg::CMD_STORE) && (r_sel == htls_pkg::TBL_MAIN));
        w_we_quies = r_clr_busy || ((r_state == ST_FIN) && w_out_free
                     && (r_cmd == htls_pkg::CMD_STORE) && (r_sel == htls_pkg::TBL_QUIES));
    end

    // main table
    always_ff @(posedge i_clk) begin
        if (w_we_main) mem_main[w_waddr] <= w_wdata;
        if (r_state == ST_RD) r_rd_main <= mem_main[r_idx];
    end

    // quiescent table
    always_ff @(posedge i_clk) begin
        if (w_we_quies) mem_quies[w_waddr] <= w_wdata;
        if (r_state == ST_RD) r_rd_quies <= mem_quies[r_idx];
    end

    // key compare
    always_comb begin
        w_rd_ent = (r_sel == htls_pkg::TBL_QUIES) ? r_rd_quies : r_rd_main;
        w_hit    = (r_cmd == htls_pkg::CMD_LOOKUP) && (w_rd_ent[KEY_W-1:0] == r_key);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            priority if ((r_state == ST_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_hit <= w_hit;
            if (w_hit) begin
                r_out_data <= {w_rd_ent[KD_LO +: KIND_W],
                               MOVE_W'(w_rd_ent[MV_LO +: MOVE_BITS]),
                               w_rd_ent[SC_LO +: SCORE_W],
                               w_rd_ent[DP_LO +: DEPTH_W]};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;

    // checks
    `ASSERT_IMP(a_no_take_clr, r_clr_busy, !s_axis_tready, "item taken during clearing pass")
    `ASSERT_NXT(a_acc_to_div, w_in_acc, r_state == ST_DIV, "accepted item did not start")
    `ASSERT_IMP(a_done_in_div, w_div_done, r_state == ST_DIV, "remainder done outside divide")

endmodule
